### src/swsc_pkg.sv
// ----------------------------------------------------------------------------
// swsc_pkg
// Shared types and constants for the sliding window sender control core:
// event and result codes, register indexes, reset values and the job record
// passed from the event front end to the result sequencer.
// ----------------------------------------------------------------------------
package swsc_pkg;

    localparam int BUF_SLOTS_DEFAULT = 32;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [2:0] DUP_ACK_LIMIT_RESET = 3'd3;
    localparam logic [3:0] TIMEOUT_LIMIT_RESET = 4'd5;

    localparam logic [7:0] OLDEST_RESET      = 8'd0;
    localparam logic [7:0] NEWEST_SENT_RESET = 8'd255;
    localparam logic [7:0] NEWEST_QUEUED_RST = 8'd255;
    localparam logic [7:0] WINDOW_RESET      = 8'd1;

    localparam logic [2:0] REPEAT_MAX  = 3'd7;
    localparam logic [4:0] TIMEOUT_MAX = 5'd31;

    typedef enum logic [1:0] {
        CMD_CHUNK   = 2'd0,
        CMD_ACK     = 2'd1,
        CMD_NACK    = 2'd2,
        CMD_TIMEOUT = 2'd3
    } cmd_t;

    typedef enum logic {
        CFG_DUP_ACK_LIMIT = 1'b0,
        CFG_TIMEOUT_LIMIT = 1'b1
    } cfg_index_t;

    localparam logic [2:0] KIND_NEW     = 3'd0;
    localparam logic [2:0] KIND_NACK    = 3'd1;
    localparam logic [2:0] KIND_FAST    = 3'd2;
    localparam logic [2:0] KIND_TIMEOUT = 3'd3;
    localparam logic [2:0] KIND_NONE    = 3'd4;

    typedef struct packed {
        logic       one_valid;
        logic [7:0] one_seq;
        logic [2:0] one_kind;
        logic [7:0] run_start;
        logic [7:0] run_cnt;
        logic [2:0] run_kind;
        logic       dropped;
        logic       aborted;
        logic [5:0] buffered;
    } job_t;

endpackage

### src/swsc_front.sv
// ----------------------------------------------------------------------------
// swsc_front
// Event front end: holds the window state and limits, classifies each event
// combinationally and hands a job record describing its results to the queue.
// ----------------------------------------------------------------------------
module swsc_front #(
    parameter int BUF_SLOTS = swsc_pkg::BUF_SLOTS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             event_valid,
    output logic             event_ready,
    input  logic [1:0]       cmd,
    input  logic [7:0]       seq,
    input  logic [7:0]       peer_win,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [3:0]       cfg_data,
    input  logic             queue_full,
    output logic             job_push,
    output swsc_pkg::job_t   job
);
    import swsc_pkg::*;

    localparam logic [7:0] BUF_SLOTS_W = 8'(BUF_SLOTS);

    logic [2:0] dup_lim_reg;
    logic [3:0] to_lim_reg;
    logic [7:0] o_reg, o_next;
    logic [7:0] ns_reg, ns_next;
    logic [7:0] nq_reg, nq_next;
    logic [7:0] win_reg, win_next;
    logic [2:0] rep_reg, rep_next;
    logic [4:0] tc_reg, tc_next;
    logic       abort_reg, abort_next;

    logic [7:0] q_cnt, s_cnt, ack_off;
    logic [7:0] f_q, f_s, gap, room, fill_cnt;
    logic [2:0] rep_inc;
    logic [4:0] tc_inc;
    logic       do_fill;
    logic       drop;
    logic       accept;

    assign event_ready = !queue_full;
    assign accept      = event_valid && event_ready;
    assign job_push    = accept;

    always_comb
    begin
        q_cnt      = nq_reg + 8'd1 - o_reg;
        s_cnt      = ns_reg + 8'd1 - o_reg;
        ack_off    = seq - o_reg;
        rep_inc    = (rep_reg == REPEAT_MAX) ? REPEAT_MAX : rep_reg + 3'd1;
        tc_inc     = (tc_reg == TIMEOUT_MAX) ? TIMEOUT_MAX : tc_reg + 5'd1;
        o_next     = o_reg;
        ns_next    = ns_reg;
        nq_next    = nq_reg;
        win_next   = win_reg;
        rep_next   = rep_reg;
        tc_next    = tc_reg;
        abort_next = abort_reg;
        do_fill    = 1'b0;
        drop       = 1'b0;
        job        = '0;
        job.one_kind = KIND_NONE;
        job.run_kind = KIND_NEW;

        if (abort_reg)
        begin
            drop = 1'b1;
        end
        else
        begin
            unique case (cmd_t'(cmd))
                CMD_CHUNK:
                begin
                    if (q_cnt >= BUF_SLOTS_W)
                        drop = 1'b1;
                    else
                        nq_next = nq_reg + 8'd1;
                    do_fill = 1'b1;
                end
                CMD_ACK, CMD_NACK:
                begin
                    tc_next = '0;
                    do_fill = 1'b1;
                    if (ack_off > s_cnt)
                    begin
                        drop = 1'b1;
                    end
                    else
                    begin
                        win_next = peer_win;
                        if (cmd_t'(cmd) == CMD_NACK)
                        begin
                            if (ack_off < q_cnt)
                            begin
                                job.one_valid = 1'b1;
                                job.one_seq   = seq;
                                job.one_kind  = KIND_NACK;
                            end
                            else
                            begin
                                drop = 1'b1;
                            end
                        end
                        else if (ack_off == 8'd0)
                        begin
                            // repeated ack, fast resend of the oldest slot once the repeat count reaches the limit
                            if (rep_inc >= dup_lim_reg)
                            begin
                                rep_next = '0;
                                if (q_cnt != 8'd0)
                                begin
                                    job.one_valid = 1'b1;
                                    job.one_seq   = o_reg;
                                    job.one_kind  = KIND_FAST;
                                end
                            end
                            else
                            begin
                                rep_next = rep_inc;
                            end
                        end
                        else
                        begin
                            o_next   = seq;
                            rep_next = '0;
                        end
                    end
                end
                CMD_TIMEOUT:
                begin
                    if (q_cnt == 8'd0)
                    begin
                        drop = 1'b1;
                    end
                    else
                    begin
                        tc_next = tc_inc;
                        if (tc_inc > {1'b0, to_lim_reg})
                        begin
                            abort_next = 1'b1;
                        end
                        else
                        begin
                            // go-back-n: resend every outstanding slot
                            job.run_start = o_reg;
                            job.run_cnt   = s_cnt;
                            job.run_kind  = KIND_TIMEOUT;
                            rep_next      = '0;
                        end
                    end
                end
                default:
                begin
                    drop = 1'b1;
                end
            endcase
        end

        // new sends while outstanding count is below the peer window, filling up to it
        f_q  = nq_next + 8'd1 - o_next;
        f_s  = ns_reg + 8'd1 - o_next;
        gap  = nq_next - ns_reg;
        room = win_next - f_s;
        if (f_q != 8'd0 && win_next > f_s)
            fill_cnt = (gap < room) ? gap : room;
        else
            fill_cnt = 8'd0;

        if (do_fill)
        begin
            job.run_start = ns_reg + 8'd1;
            job.run_cnt   = fill_cnt;
            job.run_kind  = KIND_NEW;
            ns_next       = ns_reg + fill_cnt;
        end

        if (!job.one_valid && job.run_cnt == 8'd0)
        begin
            job.one_valid = 1'b1;
            job.one_seq   = 8'd0;
            job.one_kind  = KIND_NONE;
        end

        job.dropped  = drop;
        job.aborted  = abort_next;
        job.buffered = f_q[5:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dup_lim_reg <= DUP_ACK_LIMIT_RESET;
            to_lim_reg  <= TIMEOUT_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_DUP_ACK_LIMIT: dup_lim_reg <= cfg_data[2:0];
                CFG_TIMEOUT_LIMIT: to_lim_reg  <= cfg_data;
                default:           to_lim_reg  <= to_lim_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_reg     <= OLDEST_RESET;
            ns_reg    <= NEWEST_SENT_RESET;
            nq_reg    <= NEWEST_QUEUED_RST;
            win_reg   <= WINDOW_RESET;
            rep_reg   <= '0;
            tc_reg    <= '0;
            abort_reg <= 1'b0;
        end
        else if (accept)
        begin
            o_reg     <= o_next;
            ns_reg    <= ns_next;
            nq_reg    <= nq_next;
            win_reg   <= win_next;
            rep_reg   <= rep_next;
            tc_reg    <= tc_next;
            abort_reg <= abort_next;
        end
    end

endmodule

### src/swsc_queue.sv
// ----------------------------------------------------------------------------
// swsc_queue
// Short job queue between the event front end and the result sequencer.
// ----------------------------------------------------------------------------
module swsc_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  swsc_pkg::job_t   push_job,
    input  logic             pop,
    output swsc_pkg::job_t   head_job,
    output logic             not_empty,
    output logic             full
);
    import swsc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_W  = CNT_W'(QUEUE_DEPTH);

    job_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign head_job  = mem_reg[rd_ptr_reg];
    assign not_empty = (cnt_reg != '0);
    assign full      = (cnt_reg == DEPTH_W);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

### src/swsc_back.sv
// ----------------------------------------------------------------------------
// swsc_back
// Result sequencer: takes one job at a time and emits its results, the
// single resend or none result first, then the run of sequence numbers.
// ----------------------------------------------------------------------------
module swsc_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             job_avail,
    input  swsc_pkg::job_t   job,
    output logic             job_pop,
    output logic             send_valid,
    input  logic             send_ready,
    output logic [7:0]       send_seq,
    output logic [2:0]       send_kind,
    output logic             dropped,
    output logic             aborted,
    output logic [5:0]       buffered,
    output logic             last
);
    import swsc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } state_t;

    state_t     state_reg, state_next;
    job_t       cur_reg, cur_next;
    logic       one_pend_reg, one_pend_next;
    logic [7:0] run_seq_reg, run_seq_next;
    logic [7:0] run_left_reg, run_left_next;

    logic       valid_reg, valid_next;
    logic [7:0] seq_reg, seq_next;
    logic [2:0] kind_reg, kind_next;
    logic       drop_reg, drop_next;
    logic       abort_reg, abort_next;
    logic [5:0] buf_reg, buf_next;
    logic       last_reg, last_next;
    logic       load;

    assign send_valid = valid_reg;
    assign send_seq   = seq_reg;
    assign send_kind  = kind_reg;
    assign dropped    = drop_reg;
    assign aborted    = abort_reg;
    assign buffered   = buf_reg;
    assign last       = last_reg;

    assign load = !valid_reg || send_ready;

    always_comb
    begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        one_pend_next = one_pend_reg;
        run_seq_next  = run_seq_reg;
        run_left_next = run_left_reg;
        valid_next    = valid_reg && !send_ready;
        seq_next      = seq_reg;
        kind_next     = kind_reg;
        drop_next     = drop_reg;
        abort_next    = abort_reg;
        buf_next      = buf_reg;
        last_next     = last_reg;
        job_pop       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (job_avail)
                begin
                    job_pop       = 1'b1;
                    cur_next      = job;
                    one_pend_next = job.one_valid;
                    run_seq_next  = job.run_start;
                    run_left_next = job.run_cnt;
                    state_next    = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (load)
                begin
                    valid_next = 1'b1;
                    drop_next  = cur_reg.dropped;
                    abort_next = cur_reg.aborted;
                    buf_next   = cur_reg.buffered;
                    if (one_pend_reg)
                    begin
                        seq_next      = cur_reg.one_seq;
                        kind_next     = cur_reg.one_kind;
                        last_next     = (run_left_reg == 8'd0);
                        one_pend_next = 1'b0;
                    end
                    else
                    begin
                        seq_next      = run_seq_reg;
                        kind_next     = cur_reg.run_kind;
                        last_next     = (run_left_reg == 8'd1);
                        run_seq_next  = run_seq_reg + 8'd1;
                        run_left_next = run_left_reg - 8'd1;
                    end
                    if (last_next)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            one_pend_reg <= 1'b0;
            run_left_reg <= '0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            one_pend_reg <= one_pend_next;
            run_left_reg <= run_left_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        run_seq_reg <= run_seq_next;
        seq_reg     <= seq_next;
        kind_reg    <= kind_next;
        drop_reg    <= drop_next;
        abort_reg   <= abort_next;
        buf_reg     <= buf_next;
        last_reg    <= last_next;
    end

endmodule

### src/sliding_window_sender_control_core.sv
// ----------------------------------------------------------------------------
// sliding_window_sender_control_core
// Go-back-N sender window controller with 8-bit wrapping sequence numbers.
// ----------------------------------------------------------------------------
// Each event transaction (chunk queued, ack, nack, timeout) is classified
// combinationally by the front end and queued as a job; the queue holds two
// jobs, so events keep being accepted while results drain, until it fills.
// The result sequencer takes a job in its idle state, then emits one result
// transaction per cycle while send_ready is high, so the sustained rate is
// set by the result count, up to 33 results for one event. Configuration
// writes take effect at once; the user must make them only while the block
// is idle, and the block itself does not enforce this.
module sliding_window_sender_control_core #(
    parameter int BUF_SLOTS = swsc_pkg::BUF_SLOTS_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       event_valid,
    output logic       event_ready,
    input  logic [1:0] cmd,
    input  logic [7:0] seq,
    input  logic [7:0] peer_win,
    output logic       send_valid,
    input  logic       send_ready,
    output logic [7:0] send_seq,
    output logic [2:0] send_kind,
    output logic       dropped,
    output logic       aborted,
    output logic [5:0] buffered,
    output logic       last,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [3:0] cfg_data
);
    import swsc_pkg::*;

    job_t push_job;
    job_t head_job;
    logic job_push;
    logic job_pop;
    logic queue_full;
    logic queue_not_empty;

    swsc_front #(
        .BUF_SLOTS (BUF_SLOTS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .event_valid (event_valid),
        .event_ready (event_ready),
        .cmd         (cmd),
        .seq         (seq),
        .peer_win    (peer_win),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .queue_full  (queue_full),
        .job_push    (job_push),
        .job         (push_job)
    );

    swsc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_job  (push_job),
        .pop       (job_pop),
        .head_job  (head_job),
        .not_empty (queue_not_empty),
        .full      (queue_full)
    );

    swsc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_avail  (queue_not_empty),
        .job        (head_job),
        .job_pop    (job_pop),
        .send_valid (send_valid),
        .send_ready (send_ready),
        .send_seq   (send_seq),
        .send_kind  (send_kind),
        .dropped    (dropped),
        .aborted    (aborted),
        .buffered   (buffered),
        .last       (last)
    );

endmodule

### src/swsc_checker.sv
// ----------------------------------------------------------------------------
// swsc_checker
// Port-level checks for the sliding window sender control core, bound to
// the top level.
// ----------------------------------------------------------------------------
module swsc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       send_valid,
    input logic       send_ready,
    input logic [7:0] send_seq,
    input logic [2:0] send_kind,
    input logic       dropped,
    input logic       aborted,
    input logic       last
);
    import swsc_pkg::*;

    // stalled result transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        send_valid && !send_ready |=> send_valid && $stable(send_seq)
            && $stable(send_kind) && $stable(last))
        else $error("stalled result changed");

    // a none result stands alone and carries sequence zero
    assert property (@(posedge clk) disable iff (!rst_n)
        send_valid && send_kind == KIND_NONE |-> last && send_seq == 8'd0)
        else $error("none result not alone");

    // nothing is transmitted once aborted
    assert property (@(posedge clk) disable iff (!rst_n)
        send_valid && send_kind != KIND_NONE |-> !aborted)
        else $error("transmission after abort");

    // abort is sticky
    assert property (@(posedge clk) disable iff (!rst_n)
        send_valid && aborted |=> aborted)
        else $error("abort flag cleared");

    // a timeout resend never belongs to an ignored event
    assert property (@(posedge clk) disable iff (!rst_n)
        send_valid && send_kind == KIND_TIMEOUT |-> !dropped)
        else $error("timeout resend on dropped event");

endmodule

bind sliding_window_sender_control_core swsc_checker u_swsc_checker (.*);
